@@ sv/zt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zt_pkg: shared constants and types for the Z to T parameter converter
// Widths of the numerator, divisor and quotient datapaths, register indexes,
// status codes and the structs that pass between the sub-blocks.
// ----------------------------------------------------------------------------
package zt_pkg;

  localparam int DW    = 32;            // field width
  localparam int FB    = 16;            // fraction bits
  localparam int AW    = DW + 1;        // z +/- reference
  localparam int PW    = 2 * DW + 1;    // z12 * z21 parts
  localparam int MW    = 2 * AW + 1;    // (z11 +/- z1)(z22 +/- z2) parts
  localparam int NW    = MW + 1;        // numerator before conj(z21)
  localparam int ZZW   = 2 * DW;        // |z21|^2
  localparam int QW    = DW + 2 * FB;   // ref ratio quotient
  localparam int KW    = QW / 2;        // its square root
  localparam int CW    = $clog2(QW);    // sequencer step counter width
  localparam int SMW   = DW + KW - FB;  // scale magnitude
  localparam int SLW   = SMW / 2;
  localparam int SHW   = SMW - SLW;
  localparam int ZLW   = ZZW / 2;
  localparam int ZHW   = ZZW - ZLW;
  localparam int DENW  = SMW + ZZW;     // divisor
  localparam int NLW   = NW / 2;        // low slice of numerator for split multiply
  localparam int NHW   = NW - NLW;
  localparam int MMW   = NW + DW;       // numerator times conj(z21)
  localparam int NUMW  = MMW + FB;      // dividend magnitude
  localparam int RW    = DENW + DW;     // partial remainder
  localparam int LANES = 8;             // four complex entries
  localparam int NUM_ST = 6;
  localparam int DIV_ST = DW + 2;
  localparam int NS    = NUM_ST + DIV_ST;

  localparam int CIW = 2;
  localparam logic [CIW-1:0] REG_REF1_RE = 2'd0;
  localparam logic [CIW-1:0] REG_REF1_IM = 2'd1;
  localparam logic [CIW-1:0] REG_REF2_RE = 2'd2;
  localparam logic [CIW-1:0] REG_REF2_IM = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIV0 = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  // 50 ohms
  localparam logic [DW-1:0] REF_RE_RST = DW'(50) << FB;

  typedef struct packed {
    logic [DW-1:0]  ref1_re;
    logic [DW-1:0]  ref1_im;
    logic [DW-1:0]  ref2_re;
    logic [DW-1:0]  ref2_im;
    logic [SMW-1:0] smag;
    logic           zero;
  } cfg_t;

  typedef struct packed {
    logic [LANES-1:0]           sgn;
    logic [LANES-1:0][NUMW-1:0] mag;
    logic [DENW-1:0]            den;
    logic                       zero;
  } num_t;

  typedef struct packed {
    logic [LANES-1:0][DW-1:0] t;
    logic [1:0]               status;
  } res_t;

endpackage

@@ sv/zt_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zt_cfg: reference impedance registers and scale sequencer
// Holds the four registers and, after reset or a write, works out the
// divisor scale 2*|Re z2|*sqrt(|Re z1|/|Re z2|) with a serial divider,
// a serial square root and one multiply.
// ----------------------------------------------------------------------------
module zt_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [zt_pkg::CIW-1:0]    cfg_idx,
  input  logic [zt_pkg::DW-1:0]     cfg_wdata,
  output zt_pkg::cfg_t              cfg,
  output logic                      busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]                         state;
  logic [zt_pkg::CW-1:0]              cnt;
  logic [zt_pkg::DW-1:0]              ref1_re, ref1_im, ref2_re, ref2_im;
  logic [zt_pkg::DW:0]                rem;
  logic [zt_pkg::QW-1:0]              dvd;
  logic [zt_pkg::DW-1:0]              dvs;
  logic [zt_pkg::QW-1:0]              res;
  logic [zt_pkg::QW-1:0]              bitm;
  logic [zt_pkg::DW+zt_pkg::KW-1:0]   prod;
  logic [zt_pkg::SMW-1:0]             smag;
  logic                               zero;

  logic [zt_pkg::DW-1:0]              r1m, r2m;
  logic [zt_pkg::DW:0]                rem_sh;
  logic                               take;
  logic [zt_pkg::QW-1:0]              trial;

  assign r1m    = ref1_re[zt_pkg::DW-1] ? (~ref1_re + 1'b1) : ref1_re;
  assign r2m    = ref2_re[zt_pkg::DW-1] ? (~ref2_re + 1'b1) : ref2_re;
  assign rem_sh = {rem[zt_pkg::DW-1:0], dvd[zt_pkg::QW-1]};
  assign take   = rem_sh >= {1'b0, dvs};
  assign trial  = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref1_re <= zt_pkg::REF_RE_RST;
      ref1_im <= '0;
      ref2_re <= zt_pkg::REF_RE_RST;
      ref2_im <= '0;
      state   <= ST_START;
    end else if (cfg_we) begin
      case (cfg_idx)
        zt_pkg::REG_REF1_RE: ref1_re <= cfg_wdata;
        zt_pkg::REG_REF1_IM: ref1_im <= cfg_wdata;
        zt_pkg::REG_REF2_RE: ref2_re <= cfg_wdata;
        zt_pkg::REG_REF2_IM: ref2_im <= cfg_wdata;
        default: ;
      endcase
      state <= ST_START;
    end else begin
      case (state)
        ST_START: begin
          if (r2m == '0) begin
            zero  <= 1'b1;
            smag  <= '0;
            state <= ST_IDLE;
          end else begin
            dvd   <= zt_pkg::QW'(r1m) << (2 * zt_pkg::FB);
            dvs   <= r2m;
            rem   <= '0;
            cnt   <= zt_pkg::CW'(zt_pkg::QW - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= take ? (rem_sh - {1'b0, dvs}) : rem_sh;
          dvd <= {dvd[zt_pkg::QW-2:0], take};
          if (cnt == '0) begin
            // quotient now sits in dvd; root is taken in place
            res   <= '0;
            bitm  <= zt_pkg::QW'(1) << (zt_pkg::QW - 2);
            cnt   <= zt_pkg::CW'(zt_pkg::KW - 1);
            state <= ST_SQRT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_SQRT: begin
          if (dvd >= trial) begin
            dvd <= dvd - trial;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (cnt == '0) begin
            state <= ST_MUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_MUL: begin
          prod  <= (zt_pkg::DW+zt_pkg::KW)'(dvs) * (zt_pkg::DW+zt_pkg::KW)'(res[zt_pkg::KW-1:0]);
          state <= ST_FIN;
        end
        ST_FIN: begin
          smag  <= prod[zt_pkg::FB-1 +: zt_pkg::SMW];
          zero  <= prod[zt_pkg::FB-1 +: zt_pkg::SMW] == '0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy        = state != ST_IDLE;
  assign cfg.ref1_re = ref1_re;
  assign cfg.ref1_im = ref1_im;
  assign cfg.ref2_re = ref2_re;
  assign cfg.ref2_im = ref2_im;
  assign cfg.smag    = smag;
  assign cfg.zero    = zero;

endmodule

@@ sv/zt_num.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zt_num: numerator and divisor pipeline
// Six stages: reference sums, products, numerators, split multiplies by
// conj(z21), their sums, then sign and magnitude ready for the divider.
// ----------------------------------------------------------------------------
module zt_num (
  input  logic                             clk,
  input  logic [zt_pkg::NUM_ST-1:0]        ld,
  input  logic signed [zt_pkg::DW-1:0]     z11_re,
  input  logic signed [zt_pkg::DW-1:0]     z11_im,
  input  logic signed [zt_pkg::DW-1:0]     z12_re,
  input  logic signed [zt_pkg::DW-1:0]     z12_im,
  input  logic signed [zt_pkg::DW-1:0]     z21_re,
  input  logic signed [zt_pkg::DW-1:0]     z21_im,
  input  logic signed [zt_pkg::DW-1:0]     z22_re,
  input  logic signed [zt_pkg::DW-1:0]     z22_im,
  input  zt_pkg::cfg_t                     cfg,
  output zt_pkg::num_t                     num
);

  logic signed [zt_pkg::DW-1:0] r1_re, r1_im, r2_re, r2_im;
  assign r1_re = $signed(cfg.ref1_re);
  assign r1_im = $signed(cfg.ref1_im);
  assign r2_re = $signed(cfg.ref2_re);
  assign r2_im = $signed(cfg.ref2_im);

  // stage A: index 0 is the minus/conj form, 1 the plus form
  logic signed [zt_pkg::AW-1:0]   a_re [0:1], a_im [0:1], b_re [0:1], b_im [0:1];
  logic signed [2*zt_pkg::DW-1:0] prr_a, pii_a, pri_a, pir_a, zr2_a, zi2_a;
  logic signed [zt_pkg::DW-1:0]   zr_a, zi_a;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      a_re[0] <= zt_pkg::AW'(z11_re) - zt_pkg::AW'(r1_re);
      a_im[0] <= zt_pkg::AW'(z11_im) + zt_pkg::AW'(r1_im);
      a_re[1] <= zt_pkg::AW'(z11_re) + zt_pkg::AW'(r1_re);
      a_im[1] <= zt_pkg::AW'(z11_im) + zt_pkg::AW'(r1_im);
      b_re[0] <= zt_pkg::AW'(z22_re) - zt_pkg::AW'(r2_re);
      b_im[0] <= zt_pkg::AW'(z22_im) + zt_pkg::AW'(r2_im);
      b_re[1] <= zt_pkg::AW'(z22_re) + zt_pkg::AW'(r2_re);
      b_im[1] <= zt_pkg::AW'(z22_im) + zt_pkg::AW'(r2_im);
      prr_a   <= z12_re * z21_re;
      pii_a   <= z12_im * z21_im;
      pri_a   <= z12_re * z21_im;
      pir_a   <= z12_im * z21_re;
      zr2_a   <= z21_re * z21_re;
      zi2_a   <= z21_im * z21_im;
      zr_a    <= z21_re;
      zi_a    <= z21_im;
    end
  end

  // stage B: products of the sums, z12*z21, |z21|^2
  logic signed [2*zt_pkg::AW-1:0] rr_b [0:1][0:1], ii_b [0:1][0:1];
  logic signed [2*zt_pkg::AW-1:0] ri_b [0:1][0:1], ir_b [0:1][0:1];
  logic signed [zt_pkg::PW-1:0]   p_re_b, p_im_b;
  logic [zt_pkg::ZZW-1:0]         zz_b;
  logic signed [zt_pkg::DW-1:0]   zr_b, zi_b;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 2; i++) begin
        for (int k = 0; k < 2; k++) begin
          rr_b[i][k] <= a_re[i] * b_re[k];
          ii_b[i][k] <= a_im[i] * b_im[k];
          ri_b[i][k] <= a_re[i] * b_im[k];
          ir_b[i][k] <= a_im[i] * b_re[k];
        end
      end
      p_re_b <= zt_pkg::PW'(prr_a) - zt_pkg::PW'(pii_a);
      p_im_b <= zt_pkg::PW'(pri_a) + zt_pkg::PW'(pir_a);
      zz_b   <= $unsigned(zr2_a) + $unsigned(zi2_a);
      zr_b   <= zr_a;
      zi_b   <= zi_a;
    end
  end

  // stage C: entry numerators (t12, t22 negated here), divisor partials
  logic signed [zt_pkg::NW-1:0]           n_re [0:3], n_im [0:3];
  logic [zt_pkg::SLW+zt_pkg::ZLW-1:0]     dp0_c;
  logic [zt_pkg::SHW+zt_pkg::ZLW-1:0]     dp1_c;
  logic [zt_pkg::SLW+zt_pkg::ZHW-1:0]     dp2_c;
  logic [zt_pkg::SHW+zt_pkg::ZHW-1:0]     dp3_c;
  logic                                   zero_c;
  logic signed [zt_pkg::DW-1:0]           zr_c, zi_c;

  logic [zt_pkg::SLW-1:0] s_lo;
  logic [zt_pkg::SHW-1:0] s_hi;
  logic [zt_pkg::ZLW-1:0] z_lo;
  logic [zt_pkg::ZHW-1:0] z_hi;
  assign s_lo = cfg.smag[zt_pkg::SLW-1:0];
  assign s_hi = cfg.smag[zt_pkg::SMW-1:zt_pkg::SLW];
  assign z_lo = zz_b[zt_pkg::ZLW-1:0];
  assign z_hi = zz_b[zt_pkg::ZZW-1:zt_pkg::ZLW];

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      for (int e = 0; e < 4; e++) begin
        if (e[0]) begin
          n_re[e] <= zt_pkg::NW'(rr_b[e/2][e%2]) - zt_pkg::NW'(ii_b[e/2][e%2])
                     - zt_pkg::NW'(p_re_b);
          n_im[e] <= zt_pkg::NW'(ri_b[e/2][e%2]) + zt_pkg::NW'(ir_b[e/2][e%2])
                     - zt_pkg::NW'(p_im_b);
        end else begin
          n_re[e] <= zt_pkg::NW'(p_re_b) - zt_pkg::NW'(rr_b[e/2][e%2])
                     + zt_pkg::NW'(ii_b[e/2][e%2]);
          n_im[e] <= zt_pkg::NW'(p_im_b) - zt_pkg::NW'(ri_b[e/2][e%2])
                     - zt_pkg::NW'(ir_b[e/2][e%2]);
        end
      end
      dp0_c  <= (zt_pkg::SLW+zt_pkg::ZLW)'(s_lo) * (zt_pkg::SLW+zt_pkg::ZLW)'(z_lo);
      dp1_c  <= (zt_pkg::SHW+zt_pkg::ZLW)'(s_hi) * (zt_pkg::SHW+zt_pkg::ZLW)'(z_lo);
      dp2_c  <= (zt_pkg::SLW+zt_pkg::ZHW)'(s_lo) * (zt_pkg::SLW+zt_pkg::ZHW)'(z_hi);
      dp3_c  <= (zt_pkg::SHW+zt_pkg::ZHW)'(s_hi) * (zt_pkg::SHW+zt_pkg::ZHW)'(z_hi);
      zero_c <= cfg.zero | (zz_b == '0);
      zr_c   <= zr_b;
      zi_c   <= zi_b;
    end
  end

  // stage D: split multiplies by conj(z21); k: re*zr, im*zi, im*zr, re*zi
  logic signed [zt_pkg::NLW+zt_pkg::DW:0]   lp_c [0:3][0:3];
  logic signed [zt_pkg::NHW+zt_pkg::DW-1:0] hp_c [0:3][0:3];
  logic signed [zt_pkg::NLW+zt_pkg::DW:0]   lp_d [0:3][0:3];
  logic signed [zt_pkg::NHW+zt_pkg::DW-1:0] hp_d [0:3][0:3];
  logic [zt_pkg::DENW-1:0]                  den_d;
  logic                                     zero_d;

  always_comb begin
    logic signed [zt_pkg::NW-1:0] nsel;
    logic signed [zt_pkg::DW-1:0] zsel;
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < 4; k++) begin
        nsel = (k == 0 || k == 3) ? n_re[e] : n_im[e];
        zsel = (k == 0 || k == 2) ? zr_c : zi_c;
        lp_c[e][k] = $signed({1'b0, nsel[zt_pkg::NLW-1:0]}) * zsel;
        hp_c[e][k] = $signed(nsel[zt_pkg::NW-1:zt_pkg::NLW]) * zsel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      lp_d   <= lp_c;
      hp_d   <= hp_c;
      den_d  <= zt_pkg::DENW'(dp0_c)
              + (zt_pkg::DENW'(dp1_c) << zt_pkg::SLW)
              + (zt_pkg::DENW'(dp2_c) << zt_pkg::ZLW)
              + (zt_pkg::DENW'(dp3_c) << (zt_pkg::SLW + zt_pkg::ZLW));
      zero_d <= zero_c;
    end
  end

  // stage E: recombine halves, form N * conj(z21)
  logic signed [zt_pkg::MMW-1:0] pr_d [0:3][0:3];
  logic signed [zt_pkg::MMW-1:0] m_e [0:zt_pkg::LANES-1];
  logic [zt_pkg::DENW-1:0]       den_e;
  logic                          zero_e;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      for (int k = 0; k < 4; k++) begin
        pr_d[e][k] = (zt_pkg::MMW'(hp_d[e][k]) <<< zt_pkg::NLW) + zt_pkg::MMW'(lp_d[e][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int e = 0; e < 4; e++) begin
        m_e[2*e]   <= pr_d[e][0] + pr_d[e][1];
        m_e[2*e+1] <= pr_d[e][2] - pr_d[e][3];
      end
      den_e  <= den_d;
      zero_e <= zero_d;
    end
  end

  // stage F: sign (with sign of Re z2) and scaled magnitude
  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int l = 0; l < zt_pkg::LANES; l++) begin
        num.sgn[l] <= m_e[l][zt_pkg::MMW-1] ^ cfg.ref2_re[zt_pkg::DW-1];
        num.mag[l] <= zt_pkg::NUMW'(m_e[l][zt_pkg::MMW-1] ? (~m_e[l] + 1'b1) : m_e[l])
                      << zt_pkg::FB;
      end
      num.den  <= den_e;
      num.zero <= zero_e;
    end
  end

endmodule

@@ sv/zt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zt_div: pipelined restoring divider with saturation
// One range check stage, one quotient bit per stage for all eight lanes,
// then clamping and status.
// ----------------------------------------------------------------------------
module zt_div (
  input  logic                       clk,
  input  logic [zt_pkg::DIV_ST-1:0]  ld,
  input  zt_pkg::num_t               num,
  output zt_pkg::res_t               res
);

  localparam int DW = zt_pkg::DW;
  localparam int LN = zt_pkg::LANES;
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXV = ~MINV;

  logic [zt_pkg::RW-1:0]   rem_s  [0:DW][0:LN-1];
  logic [DW-1:0]           q_s    [0:DW][0:LN-1];
  logic                    hi_s   [0:DW][0:LN-1];
  logic [LN-1:0]           sgn_s  [0:DW];
  logic [zt_pkg::DENW-1:0] den_s  [0:DW];
  logic                    zero_s [0:DW];

  // quotient of 2^DW or more always clamps
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int l = 0; l < LN; l++) begin
        rem_s[0][l] <= zt_pkg::RW'(num.mag[l]);
        q_s[0][l]   <= '0;
        hi_s[0][l]  <= zt_pkg::RW'(num.mag[l]) >= (zt_pkg::RW'(num.den) << DW);
      end
      sgn_s[0]  <= num.sgn;
      den_s[0]  <= num.den;
      zero_s[0] <= num.zero;
    end
  end

  for (genvar j = 1; j <= DW; j++) begin : g_bit
    logic [zt_pkg::RW-1:0] dsh;
    assign dsh = zt_pkg::RW'(den_s[j-1]) << (DW - j);

    for (genvar l = 0; l < LN; l++) begin : g_lane
      logic          take;
      logic [DW-1:0] q_next;
      assign take = rem_s[j-1][l] >= dsh;
      always_comb begin
        q_next = q_s[j-1][l];
        q_next[DW-j] = take;
      end
      always_ff @(posedge clk) begin
        if (ld[j]) begin
          rem_s[j][l] <= take ? (rem_s[j-1][l] - dsh) : rem_s[j-1][l];
          q_s[j][l]   <= q_next;
          hi_s[j][l]  <= hi_s[j-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        sgn_s[j]  <= sgn_s[j-1];
        den_s[j]  <= den_s[j-1];
        zero_s[j] <= zero_s[j-1];
      end
    end
  end

  logic [DW-1:0] val [0:LN-1];
  logic          any_sat;

  always_comb begin
    logic sat;
    logic [DW-1:0] q;
    any_sat = 1'b0;
    for (int l = 0; l < LN; l++) begin
      q   = q_s[DW][l];
      sat = hi_s[DW][l] | (sgn_s[DW][l] ? (q > MINV) : q[DW-1]);
      if (sgn_s[DW][l]) begin
        val[l] = sat ? MINV : (~q + 1'b1);
      end else begin
        val[l] = sat ? MAXV : q;
      end
      any_sat = any_sat | sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[DW+1]) begin
      for (int l = 0; l < LN; l++) begin
        res.t[l] <= zero_s[DW] ? '0 : val[l];
      end
      if (zero_s[DW]) begin
        res.status <= zt_pkg::STAT_DIV0;
      end else if (any_sat) begin
        res.status <= zt_pkg::STAT_SAT;
      end else begin
        res.status <= zt_pkg::STAT_OK;
      end
    end
  end

endmodule

@@ sv/z_to_t_param_convert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_to_t_param_convert: two-port Z to T parameter converter, Q16.16
// Streams 2x2 complex impedance matrices in and T matrices out.
// ----------------------------------------------------------------------------
// One matrix can be taken every clock while in_stall is low, and its T
// matrix passes through 6 numerator stages, a range check, 32 quotient-bit
// stages and the output register, so the sustained rate is one transfer per
// cycle for as long as the output side keeps up. Each stage carries a valid
// bit and a stage only holds when the one after it is full and holding, so
// bubbles close up and input is still taken while a finished result waits.
// After reset and after every register write a serial sequencer works out
// the divisor scale 2*|Re z2|*sqrt(|Re z1|/|Re z2|) in 64 divide steps, 32
// root steps, one multiply and set-up, during which in_stall is held high.
// Write the registers only with nothing in flight. status reads 1 when the
// divisor is zero (Re z2 zero, scale truncated to zero, or z21 zero; all
// eight parts are then zero) and 2 when any part was clamped.
// ----------------------------------------------------------------------------
module z_to_t_param_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [zt_pkg::CIW-1:0]        cfg_idx,
  input  logic [zt_pkg::DW-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [zt_pkg::DW-1:0]  z11_re,
  input  logic signed [zt_pkg::DW-1:0]  z11_im,
  input  logic signed [zt_pkg::DW-1:0]  z12_re,
  input  logic signed [zt_pkg::DW-1:0]  z12_im,
  input  logic signed [zt_pkg::DW-1:0]  z21_re,
  input  logic signed [zt_pkg::DW-1:0]  z21_im,
  input  logic signed [zt_pkg::DW-1:0]  z22_re,
  input  logic signed [zt_pkg::DW-1:0]  z22_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [zt_pkg::DW-1:0]  t11_re,
  output logic signed [zt_pkg::DW-1:0]  t11_im,
  output logic signed [zt_pkg::DW-1:0]  t12_re,
  output logic signed [zt_pkg::DW-1:0]  t12_im,
  output logic signed [zt_pkg::DW-1:0]  t21_re,
  output logic signed [zt_pkg::DW-1:0]  t21_im,
  output logic signed [zt_pkg::DW-1:0]  t22_re,
  output logic signed [zt_pkg::DW-1:0]  t22_im,
  output logic [1:0]                    status
);

  zt_pkg::cfg_t cfg;
  zt_pkg::num_t num;
  zt_pkg::res_t res;
  logic         busy;

  // per-stage valid bits and load enables
  logic [zt_pkg::NS-1:0] v;
  logic [zt_pkg::NS-1:0] rdy;

  always_comb begin
    rdy[zt_pkg::NS-1] = ~v[zt_pkg::NS-1] | ~out_stall;
    for (int s = zt_pkg::NS - 2; s >= 0; s--) begin
      rdy[s] = ~v[s] | rdy[s+1];
    end
  end

  assign in_stall = busy | ~rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid & ~busy;
      end
      for (int s = 1; s < zt_pkg::NS; s++) begin
        if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  zt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .busy      (busy)
  );

  zt_num u_num (
    .clk    (clk),
    .ld     (rdy[zt_pkg::NUM_ST-1:0]),
    .z11_re (z11_re),
    .z11_im (z11_im),
    .z12_re (z12_re),
    .z12_im (z12_im),
    .z21_re (z21_re),
    .z21_im (z21_im),
    .z22_re (z22_re),
    .z22_im (z22_im),
    .cfg    (cfg),
    .num    (num)
  );

  zt_div u_div (
    .clk (clk),
    .ld  (rdy[zt_pkg::NS-1:zt_pkg::NUM_ST]),
    .num (num),
    .res (res)
  );

  assign out_valid = v[zt_pkg::NS-1];
  assign t11_re    = $signed(res.t[0]);
  assign t11_im    = $signed(res.t[1]);
  assign t12_re    = $signed(res.t[2]);
  assign t12_im    = $signed(res.t[3]);
  assign t21_re    = $signed(res.t[4]);
  assign t21_im    = $signed(res.t[5]);
  assign t22_re    = $signed(res.t[6]);
  assign t22_im    = $signed(res.t[7]);
  assign status    = res.status;

endmodule

@@ sv/zt_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zt_chk: port-level checks for the Z to T converter
// Output hold under stall, status codes, zeroed results on a zero divisor,
// and input hold-off as the scale update starts after reset or a register write.
// ----------------------------------------------------------------------------
module zt_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          in_stall,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [zt_pkg::DW-1:0]  t11_re,
  input  logic signed [zt_pkg::DW-1:0]  t11_im,
  input  logic signed [zt_pkg::DW-1:0]  t12_re,
  input  logic signed [zt_pkg::DW-1:0]  t12_im,
  input  logic signed [zt_pkg::DW-1:0]  t21_re,
  input  logic signed [zt_pkg::DW-1:0]  t21_im,
  input  logic signed [zt_pkg::DW-1:0]  t22_re,
  input  logic signed [zt_pkg::DW-1:0]  t22_im,
  input  logic [1:0]                    status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(t11_re) && $stable(t12_im)
      && $stable(t22_re) && $stable(status))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == zt_pkg::STAT_OK || status == zt_pkg::STAT_DIV0
      || status == zt_pkg::STAT_SAT))
    else $error("undefined status");

  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == zt_pkg::STAT_DIV0 |-> t11_re == '0 && t11_im == '0
      && t12_re == '0 && t12_im == '0 && t21_re == '0 && t21_im == '0
      && t22_re == '0 && t22_im == '0)
    else $error("zero divisor with nonzero result");

  a_rst_holdoff: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input taken before scale ready");

  a_cfg_holdoff: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall)
    else $error("input taken during scale update");

endmodule

bind z_to_t_param_convert zt_chk u_zt_chk (.*);

@@ bench/z_to_t_param_convert_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z_to_t_param_convert_tb: self-checking bench for the Z to T converter
// Streams impedance matrices through the block under a range of reference
// impedance settings and flow-control patterns. Every accepted matrix is
// converted by an in-bench model of the fixed-point datapath, and each T
// matrix that leaves the block is compared, part by part and with status,
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module z_to_t_param_convert_tb;

  localparam int DW          = zt_pkg::DW;
  localparam int FB          = zt_pkg::FB;
  localparam int CIW         = zt_pkg::CIW;
  localparam int HALF_PERIOD = 2;
  localparam int SETTLE      = 60;      // settle time, longer than the pipe
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // one input matrix: z11 re/im, z12 re/im, z21 re/im, z22 re/im
  typedef struct packed {
    logic [7:0][DW-1:0] z;
  } zmat_t;

  // one T matrix: t11 re/im .. t22 re/im, then status
  typedef struct packed {
    logic [7:0][DW-1:0] t;
    logic [1:0]         st;
  } tmat_t;

  // 128-bit two's complement complex value
  typedef struct packed {
    logic [127:0] re;
    logic [127:0] im;
  } cw_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CIW-1:0] cfg_idx = '0;
  logic [DW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [DW-1:0] z11_re = '0, z11_im = '0, z12_re = '0, z12_im = '0;
  logic [DW-1:0] z21_re = '0, z21_im = '0, z22_re = '0, z22_im = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] t11_re, t11_im, t12_re, t12_im, t21_re, t21_im, t22_re, t22_im;
  logic [1:0]    status;

  // bench copy of the reference impedance registers
  logic [DW-1:0] ref1_re_m, ref1_im_m, ref2_re_m, ref2_im_m;

  tmat_t t_expected_q[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    src_idle_pct = 0;   // chance per transfer of a sender gap cycle
  int    rcv_stall_pct = 0;  // chance per cycle of the receiver stalling
  int    rcv_hold = 0;       // forced receiver stall, in cycles

  always #HALF_PERIOD clk = ~clk;

  z_to_t_param_convert i_dut (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_wdata,
    .in_valid, .in_stall,
    .z11_re, .z11_im, .z12_re, .z12_im, .z21_re, .z21_im, .z22_re, .z22_im,
    .out_valid, .out_stall,
    .t11_re, .t11_im, .t12_re, .t12_im, .t21_re, .t21_im, .t22_re, .t22_im,
    .status
  );

  // --------------------------------------------------------------------------
  // Fixed-point model. All sums and products are kept exact in 128 bits;
  // wrap-around arithmetic is the same for signed and unsigned, so only
  // the sign tests look at bit 127.
  // --------------------------------------------------------------------------
  function automatic logic [127:0] sx(logic [DW-1:0] v);
    return {{(128-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [127:0] mag(logic [127:0] v);
    return v[127] ? -v : v;
  endfunction

  function automatic cw_t cmul(cw_t a, cw_t b);
    cw_t r;
    r.re = a.re * b.re - a.im * b.im;
    r.im = a.re * b.im + a.im * b.re;
    return r;
  endfunction

  function automatic cw_t csub(cw_t a, cw_t b);
    cw_t r;
    r.re = a.re - b.re;
    r.im = a.im - b.im;
    return r;
  endfunction

  function automatic cw_t cadd(cw_t a, cw_t b);
    cw_t r;
    r.re = a.re + b.re;
    r.im = a.im + b.im;
    return r;
  endfunction

  function automatic cw_t cconj(cw_t a);
    cw_t r;
    r.re = a.re;
    r.im = -a.im;
    return r;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // signed numerator over unsigned divisor, truncated to zero, clamped
  function automatic logic [DW-1:0] quot_clamp(logic [127:0] num, logic [127:0] den,
                                               inout logic sat);
    logic [127:0] q;
    logic [127:0] lim;
    lim = 128'h1 << (DW - 1);
    q = mag(num) / den;
    if (num[127]) begin
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      q = -q;
    end else if (q > lim - 1) begin
      sat = 1'b1;
      q = lim - 1;
    end
    return q[DW-1:0];
  endfunction

  function automatic tmat_t convert_z_to_t(zmat_t m);
    tmat_t r;
    cw_t z11, z12, z21, z22, z1, z2, p, am, ap, bm, bp, prod;
    cw_t n[4];
    logic [63:0] r1m, r2m, k;
    logic [127:0] q, smag, zz, den, nre, nim;
    logic sat;
    r = '0;
    sat = 1'b0;
    z11 = '{sx(m.z[7]), sx(m.z[6])};
    z12 = '{sx(m.z[5]), sx(m.z[4])};
    z21 = '{sx(m.z[3]), sx(m.z[2])};
    z22 = '{sx(m.z[1]), sx(m.z[0])};
    z1  = '{sx(ref1_re_m), sx(ref1_im_m)};
    z2  = '{sx(ref2_re_m), sx(ref2_im_m)};
    r1m = 64'(mag(z1.re));
    r2m = 64'(mag(z2.re));
    if (r2m == 0) begin
      r.st = zt_pkg::STAT_DIV0;
      return r;
    end
    // k = sqrt(|Re z1| / |Re z2|) and the scale 2*|Re z2|*k
    q = ({64'b0, r1m} << (2 * FB)) / {64'b0, r2m};
    k = (q[127:64] != 0) ? isqrt64('1) : isqrt64(q[63:0]);
    smag = (({64'b0, r2m} * {64'b0, k}) << 1) >> FB;
    zz = z21.re * z21.re + z21.im * z21.im;
    den = smag * zz;
    if (smag == 0 || zz == 0 || den == 0) begin
      r.st = zt_pkg::STAT_DIV0;
      return r;
    end
    p  = cmul(z12, z21);
    am = csub(z11, cconj(z1));
    ap = cadd(z11, z1);
    bm = csub(z22, cconj(z2));
    bp = cadd(z22, z2);
    n[0] = csub(p, cmul(am, bm));
    n[1] = csub(cmul(am, bp), p);
    n[2] = csub(p, cmul(ap, bm));
    n[3] = csub(cmul(ap, bp), p);
    // divide by d as N * conj(z21) / (s * |z21|^2)
    for (int i = 0; i < 4; i++) begin
      prod = cmul(n[i], cconj(z21));
      nre = prod.re << FB;
      nim = prod.im << FB;
      if (ref2_re_m[DW-1]) begin
        nre = -nre;
        nim = -nim;
      end
      r.t[7 - 2 * i] = quot_clamp(nre, den, sat);
      r.t[6 - 2 * i] = quot_clamp(nim, den, sat);
    end
    r.st = sat ? zt_pkg::STAT_SAT : zt_pkg::STAT_OK;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a forced hold-off while rcv_hold runs down.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rcv_hold > 0) begin
      out_stall = 1'b1;
      rcv_hold = rcv_hold - 1;
    end else begin
      out_stall = ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Result checker: each output transfer against the oldest prediction.
  always @(posedge clk) begin
    tmat_t act, exp_t;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      act.t  = {t11_re, t11_im, t12_re, t12_im, t21_re, t21_im, t22_re, t22_im};
      act.st = status;
      if (t_expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected T matrix %h status %0d", act.t, act.st);
      end else begin
        exp_t = t_expected_q.pop_front();
        if (act !== exp_t) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS) begin
            $display("T matrix mismatch (status exp %0d act %0d)", exp_t.st, act.st);
            for (int i = 0; i < 8; i++)
              if (act.t[7 - i] !== exp_t.t[7 - i])
                $display("  part %0d: exp %h act %h", i, exp_t.t[7 - i], act.t[7 - i]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("z_to_t_param_convert test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at a falling edge once the
  // matrix has been transferred. in_valid stays high into the next call.
  // --------------------------------------------------------------------------
  task automatic send_matrix(zmat_t m);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {z11_re, z11_im, z12_re, z12_im, z21_re, z21_im, z22_re, z22_im} = m.z;
    do @(posedge clk); while (in_stall);
    t_expected_q.push_back(convert_z_to_t(m));
    @(negedge clk);
  endtask

  // Drain the pipe and give it time to settle before touching registers.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (t_expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_refs(logic [DW-1:0] r1re, logic [DW-1:0] r1im,
                            logic [DW-1:0] r2re, logic [DW-1:0] r2im);
    logic [3:0][DW-1:0] vals;
    logic [CIW-1:0] idx [4];
    vals = {r1re, r1im, r2re, r2im};
    idx = '{zt_pkg::REG_REF1_RE, zt_pkg::REG_REF1_IM,
            zt_pkg::REG_REF2_RE, zt_pkg::REG_REF2_IM};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_idx = idx[i];
      cfg_wdata = vals[3 - i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    ref1_re_m = r1re;
    ref1_im_m = r1im;
    ref2_re_m = r2re;
    ref2_im_m = r2im;
  endtask

  // Mostly moderate impedances so the results stay in range; some full-range
  // and boundary values to reach saturation and every bit.
  function automatic logic [DW-1:0] rand_part();
    logic [DW-1:0] v;
    case ($urandom_range(9))
      0, 1:    v = $urandom;
      2: begin
        case ($urandom_range(4))
          0: v = {1'b1, {(DW-1){1'b0}}};
          1: v = {1'b0, {(DW-1){1'b1}}};
          2: v = '0;
          3: v = 1;
          default: v = '1;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(9, 20);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic zmat_t rand_matrix();
    zmat_t m;
    for (int i = 0; i < 8; i++) m.z[i] = rand_part();
    // z21 of zero makes the divisor vanish
    if ($urandom_range(29) == 0) begin
      m.z[3] = '0;
      m.z[2] = '0;
    end
    return m;
  endfunction

  function automatic logic [DW-1:0] ohms(int v);
    return DW'(v) << FB;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    logic [DW-1:0] mx, mn;
    zmat_t m;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    // all zero: z21 zero, divisor vanishes
    m.z = '0;                                            send_matrix(m);
    // z21 purely imaginary, only its imaginary part nonzero
    m.z = {ohms(10), 32'h0, ohms(5), 32'h0, 32'h0, ohms(7), ohms(20), 32'h0};
    send_matrix(m);
    // a plain resistive tee network
    m.z = {ohms(60), 32'h0, ohms(40), 32'h0, ohms(40), 32'h0, ohms(60), 32'h0};
    send_matrix(m);
    m.z = {ohms(-3), ohms(12), ohms(1), ohms(-2), ohms(2), ohms(1), ohms(8), ohms(-9)};
    send_matrix(m);
    // every part at the top, then at the bottom of the range
    m.z = {8{mx}};                                       send_matrix(m);
    m.z = {8{mn}};                                       send_matrix(m);
    m.z = {mx, mn, mx, mn, mn, mx, mn, mx};              send_matrix(m);
    // tiny z21 gives huge quotients: saturation both ways
    m.z = {ohms(100), 32'h0, ohms(100), 32'h0, 32'h1, 32'h0, ohms(3), 32'h0};
    send_matrix(m);
    m.z = {ohms(-100), 32'h0, ohms(100), 32'h0, 32'h0, 32'hFFFF_FFFF, ohms(3), 32'h0};
    send_matrix(m);
    // z21 at its extremes, z21 = -1 LSB
    m.z = {ohms(1), ohms(1), ohms(1), ohms(1), mn, mn, ohms(1), ohms(1)};
    send_matrix(m);
    m.z = {ohms(1), ohms(1), ohms(1), ohms(1), 32'hFFFF_FFFF, 32'h0, ohms(1), ohms(1)};
    send_matrix(m);
    // matched loads under the reset references: z11 = conj z1, z22 = conj z2
    m.z = {ohms(50), 32'h0, 32'h0, 32'h0, ohms(25), ohms(-25), ohms(50), 32'h0};
    send_matrix(m);
    for (int i = 0; i < 6; i++) send_matrix(rand_matrix());
  endtask

  // One random stream under each of the four flow-control patterns.
  task automatic test_random_phases(int per_phase);
    int src_p [4] = '{0, 60, 0, 6};
    int rcv_p [4] = '{0, 0, 60, 6};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_p[ph];
      rcv_stall_pct = rcv_p[ph];
      for (int i = 0; i < per_phase; i++) send_matrix(rand_matrix());
    end
    src_idle_pct = 0;
    rcv_stall_pct = 0;
  endtask

  // Long receiver hold-off with the sender pushing: the pipe fills and
  // in_stall has to rise, then everything drains in order.
  task automatic test_backpressure();
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    rcv_hold = 300;
    for (int i = 0; i < 150; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    logic [DW-1:0] mx, mn;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    ref1_re_m = zt_pkg::REF_RE_RST;
    ref1_im_m = '0;
    ref2_re_m = zt_pkg::REF_RE_RST;
    ref2_im_m = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset values first, no register written yet
    test_directed();
    test_random_phases(50);
    test_backpressure();

    write_refs(ohms(75), ohms(10), ohms(25), ohms(-5));
    test_directed();
    test_random_phases(50);

    // negative Re z2 flips the sign of every part
    write_refs(ohms(50), '0, ohms(-50), ohms(20));
    test_random_phases(50);

    // largest ratio, tiny Re z2
    write_refs(mx, mn, 32'h1, mx);
    test_random_phases(50);

    write_refs(mn, mx, mn, mn);
    test_random_phases(50);

    // Re z1 zero: the scale truncates to zero
    write_refs('0, ohms(3), ohms(50), '0);
    test_random_phases(5);

    // Re z2 zero
    write_refs(ohms(50), '0, '0, ohms(1));
    test_random_phases(5);

    write_refs(ohms(50), '0, ohms(50), '0);
    test_random_phases(57);

    wait_idle();
    if (mismatches == 0) begin
      $display("z_to_t_param_convert test passed");
    end else begin
      $display("z_to_t_param_convert test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/zt_pkg.sv
sv/zt_cfg.sv
sv/zt_num.sv
sv/zt_div.sv
sv/z_to_t_param_convert.sv
sv/zt_chk.sv
bench/z_to_t_param_convert_tb.sv
